FILE: hdl/quaternion_to_yaw_pitch_roll_core_assert.svh
// Assertion macros shared by the converter RTL.
`ifndef QUATERNION_TO_YAW_PITCH_ROLL_CORE_ASSERT_SVH
`define QUATERNION_TO_YAW_PITCH_ROLL_CORE_ASSERT_SVH

// Plain property, sampled on the clock and ignored during reset.
`define QYPR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define QYPR_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hdl/qypr_pkg.sv
// Shared widths, constants and types of the quaternion to yaw, pitch and roll converter.
package qypr_pkg;

   localparam int Q_W          = 16;
   localparam int P_W          = 32;
   localparam int RAW_W        = 35;
   localparam int IN_SHIFT     = 4;
   localparam int G_W          = 30;
   localparam int MAG_W        = 29;
   localparam int RAD_W        = 2 * MAG_W;
   localparam int ROOT_W       = RAD_W / 2;
   localparam int REM_W        = ROOT_W + 3;
   localparam int SQRT_STEPS   = RAD_W / 2;
   localparam int XY_W         = 34;
   localparam int Z_W          = 27;
   localparam int Z_FRAC       = 16;
   localparam int ANG_W        = 16;
   localparam int CORDIC_STEPS = 20;
   localparam int LANES        = 3;
   localparam int LANE_YAW     = 0;
   localparam int LANE_PITCH   = 1;
   localparam int LANE_ROLL    = 2;

   localparam logic signed [RAW_W-1:0] ONE_Q28 = 35'sd268435456;
   localparam logic signed [Z_W-1:0]   DEG180  = 27'sd11796480;

   localparam logic signed [Z_W-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
      27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945, 27'sd234379,
      27'sd117304,  27'sd58666,   27'sd29335,  27'sd14668,  27'sd7334,
      27'sd3667,    27'sd1833,    27'sd917,    27'sd458,    27'sd229,
      27'sd115,     27'sd57,      27'sd29,     27'sd14,     27'sd7
   };

   typedef struct packed {
      logic                  status;
      logic signed [G_W-1:0] gx;
      logic signed [G_W-1:0] gy;
      logic signed [G_W-1:0] gz;
      logic signed [G_W-1:0] yaw_y;
      logic signed [G_W-1:0] yaw_x;
   } grav_type;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [RAD_W-1:0]  rad;
   } sqrt_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic signed [Z_W-1:0]  z;
   } vec_type;

   typedef struct packed {
      logic             status;
      logic [LANES-1:0] zero;
      logic             gz_neg;
   } side_type;

endpackage

FILE: hdl/qypr_sqrt_cell.sv
// One digit step of the pipelined integer square root, carrying the gravity terms alongside.
module qypr_sqrt_cell (
   input  logic               clock,
   input  logic               en,
   input  qypr_pkg::sqrt_type sqrt_prev,
   input  qypr_pkg::grav_type grav_prev,
   output qypr_pkg::sqrt_type sqrt_ff,
   output qypr_pkg::grav_type grav_ff
);
   import qypr_pkg::*;

   logic [REM_W-1:0] part;
   logic [REM_W-1:0] trial;
   sqrt_type         sqrt_in;

   always_comb begin
      part        = {sqrt_prev.rem[REM_W-4:0], sqrt_prev.rad[RAD_W-1 -: 2]};
      trial       = {1'b0, sqrt_prev.root, 2'b01};
      sqrt_in.rad = sqrt_prev.rad << 2;
      if (part >= trial) begin
         sqrt_in.rem  = part - trial;
         sqrt_in.root = {sqrt_prev.root[ROOT_W-2:0], 1'b1};
      end else begin
         sqrt_in.rem  = part;
         sqrt_in.root = {sqrt_prev.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sqrt_ff <= sqrt_in;
         grav_ff <= grav_prev;
      end
   end

endmodule

FILE: hdl/qypr_cordic_cell.sv
// One vectoring micro-rotation of the CORDIC chain.
module qypr_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic              clock,
   input  logic              en,
   input  qypr_pkg::vec_type vec_prev,
   output qypr_pkg::vec_type vec_ff
);
   import qypr_pkg::*;

   logic signed [XY_W-1:0] xs;
   logic signed [XY_W-1:0] ys;
   vec_type                vec_in;

   always_comb begin
      xs = vec_prev.x >>> STEP;
      ys = vec_prev.y >>> STEP;
      if (vec_prev.y > 0) begin
         vec_in.x = vec_prev.x + ys;
         vec_in.y = vec_prev.y - xs;
         vec_in.z = vec_prev.z + ATAN_TABLE[STEP];
      end else begin
         vec_in.x = vec_prev.x - ys;
         vec_in.y = vec_prev.y + xs;
         vec_in.z = vec_prev.z - ATAN_TABLE[STEP];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_ff <= vec_in;
      end
   end

endmodule

FILE: hdl/quaternion_to_yaw_pitch_roll_core.sv
// Quaternion to yaw, pitch and roll converter, top level.
// Throughput: one transaction per cycle unless a result waits; the depth is set by the products,
// the 29-cell square root chain and the three 20-cell CORDIC chains that run side by side.
// The whole pipeline advances together and holds while a result waits to be taken.
// Synchronous reset empties the pipeline and clears ready_ff.
`include "quaternion_to_yaw_pitch_roll_core_assert.svh"

module quaternion_to_yaw_pitch_roll_core #(
   parameter int ANGLE_FRAC_BITS = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // quat_w, quat_x, quat_y, quat_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // yaw_angle, pitch_angle, roll_angle
   output logic        rsp_tuser,   // status
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);
   import qypr_pkg::*;

   localparam int DEPTH  = 4 + SQRT_STEPS + 1 + CORDIC_STEPS + 1;
   localparam int SHIFT  = Z_FRAC - ANGLE_FRAC_BITS;
   localparam logic signed [Z_W-1:0]   HALF  = Z_W'(2 ** (SHIFT - 1));
   localparam logic signed [Z_W-1:0]   LIM   = Z_W'(180 * (2 ** ANGLE_FRAC_BITS));
   localparam logic signed [ANG_W-1:0] LIM16 = ANG_W'(180 * (2 ** ANGLE_FRAC_BITS));

   logic             ready_ff;
   logic             en;
   logic [DEPTH-1:0] valid_ff;

   logic signed [Q_W-1:0] qw, qx, qy, qz;
   logic                  status1_ff;
   logic signed [P_W-1:0] p_ww_ff, p_xx_ff, p_yy_ff, p_zz_ff, p_wx_ff;
   logic signed [P_W-1:0] p_yz_ff, p_xz_ff, p_wy_ff, p_xy_ff, p_wz_ff;

   logic signed [RAW_W-1:0] gx_raw, gy_raw, gz_raw, yaw_y_raw, yaw_x_raw;
   grav_type                grav_in, grav2_ff, grav3_ff, grav4_ff;
   logic [MAG_W-1:0]        gy_abs, gz_abs;
   logic [RAD_W-1:0]        gy_sq_ff, gz_sq_ff;
   sqrt_type                sqrt4_ff;

   sqrt_type chain_sq [SQRT_STEPS+1];
   grav_type chain_gr [SQRT_STEPS+1];

   grav_type               g_end;
   logic signed [XY_W-1:0] ox [LANES];
   logic signed [XY_W-1:0] oy [LANES];
   vec_type                pre_in [LANES];
   vec_type                pre_ff [LANES];
   side_type               side_in;
   side_type               side_ff [CORDIC_STEPS+1];
   vec_type                cr [LANES][CORDIC_STEPS+1];

   logic signed [Z_W-1:0]   za  [LANES];
   logic signed [Z_W-1:0]   rnd [LANES];
   logic signed [ANG_W-1:0] ang_in [LANES];
   logic signed [ANG_W-1:0] ang_ff [LANES];
   logic                    status_ff;

   assign en         = !valid_ff[DEPTH-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = valid_ff[DEPTH-1];
   assign rsp_tdata  = {ang_ff[LANE_ROLL], ang_ff[LANE_PITCH], ang_ff[LANE_YAW]};
   assign rsp_tuser  = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= 1'b0;
      end else if (csr_wr_en) begin
         ready_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[DEPTH-2:0], req_tvalid};
      end
   end

   assign qw = req_tdata[15:0];
   assign qx = req_tdata[31:16];
   assign qy = req_tdata[47:32];
   assign qz = req_tdata[63:48];

   always_ff @(posedge clock) begin
      if (en) begin
         status1_ff <= !ready_ff;
         p_ww_ff    <= qw * qw;
         p_xx_ff    <= qx * qx;
         p_yy_ff    <= qy * qy;
         p_zz_ff    <= qz * qz;
         p_wx_ff    <= qw * qx;
         p_yz_ff    <= qy * qz;
         p_xz_ff    <= qx * qz;
         p_wy_ff    <= qw * qy;
         p_xy_ff    <= qx * qy;
         p_wz_ff    <= qw * qz;
      end
   end

   always_comb begin
      gx_raw    = (RAW_W'(p_xz_ff) - RAW_W'(p_wy_ff)) <<< 1;
      gy_raw    = (RAW_W'(p_wx_ff) + RAW_W'(p_yz_ff)) <<< 1;
      gz_raw    = RAW_W'(p_ww_ff) - RAW_W'(p_xx_ff) - RAW_W'(p_yy_ff) + RAW_W'(p_zz_ff);
      yaw_y_raw = (RAW_W'(p_xy_ff) - RAW_W'(p_wz_ff)) <<< 1;
      yaw_x_raw = ((RAW_W'(p_ww_ff) + RAW_W'(p_xx_ff)) <<< 1) - ONE_Q28;
      grav_in.status = status1_ff;
      grav_in.gx     = gx_raw[G_W+IN_SHIFT-1:IN_SHIFT];
      grav_in.gy     = gy_raw[G_W+IN_SHIFT-1:IN_SHIFT];
      grav_in.gz     = gz_raw[G_W+IN_SHIFT-1:IN_SHIFT];
      grav_in.yaw_y  = yaw_y_raw[G_W+IN_SHIFT-1:IN_SHIFT];
      grav_in.yaw_x  = yaw_x_raw[G_W+IN_SHIFT-1:IN_SHIFT];
   end

   assign gy_abs = grav2_ff.gy[G_W-1] ? MAG_W'(-grav2_ff.gy) : grav2_ff.gy[MAG_W-1:0];
   assign gz_abs = grav2_ff.gz[G_W-1] ? MAG_W'(-grav2_ff.gz) : grav2_ff.gz[MAG_W-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         grav2_ff      <= grav_in;
         grav3_ff      <= grav2_ff;
         gy_sq_ff      <= gy_abs * gy_abs;
         gz_sq_ff      <= gz_abs * gz_abs;
         grav4_ff      <= grav3_ff;
         sqrt4_ff.rem  <= '0;
         sqrt4_ff.root <= '0;
         sqrt4_ff.rad  <= gy_sq_ff + gz_sq_ff;
      end
   end

   assign chain_sq[0] = sqrt4_ff;
   assign chain_gr[0] = grav4_ff;

   for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
      qypr_sqrt_cell u_cell (
         .clock     (clock),
         .en        (en),
         .sqrt_prev (chain_sq[s]),
         .grav_prev (chain_gr[s]),
         .sqrt_ff   (chain_sq[s+1]),
         .grav_ff   (chain_gr[s+1])
      );
   end

   assign g_end = chain_gr[SQRT_STEPS];

   always_comb begin
      ox[LANE_YAW]   = XY_W'(g_end.yaw_x);
      oy[LANE_YAW]   = XY_W'(g_end.yaw_y);
      ox[LANE_PITCH] = XY_W'(chain_sq[SQRT_STEPS].root);
      oy[LANE_PITCH] = XY_W'(g_end.gx);
      ox[LANE_ROLL]  = XY_W'(g_end.gz);
      oy[LANE_ROLL]  = XY_W'(g_end.gy);
      side_in.status = g_end.status;
      side_in.gz_neg = g_end.gz[G_W-1];
      for (int k = 0; k < LANES; k++) begin
         side_in.zero[k] = (ox[k] == '0) && (oy[k] == '0);
         if (ox[k] < 0) begin
            pre_in[k].x = -ox[k];
            pre_in[k].y = -oy[k];
            pre_in[k].z = (oy[k] >= 0) ? DEG180 : -DEG180;
         end else begin
            pre_in[k].x = ox[k];
            pre_in[k].y = oy[k];
            pre_in[k].z = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int s = 1; s <= CORDIC_STEPS; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
         for (int k = 0; k < LANES; k++) begin
            pre_ff[k] <= pre_in[k];
         end
      end
   end

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      assign cr[k][0] = pre_ff[k];
      for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
         qypr_cordic_cell #(.STEP(s)) u_cell (
            .clock    (clock),
            .en       (en),
            .vec_prev (cr[k][s]),
            .vec_ff   (cr[k][s+1])
         );
      end
   end

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         za[k] = side_ff[CORDIC_STEPS].zero[k] ? '0 : cr[k][CORDIC_STEPS].z;
         if ((k == LANE_PITCH) && side_ff[CORDIC_STEPS].gz_neg) begin
            za[k] = (za[k] > 0) ? (DEG180 - za[k]) : (-DEG180 - za[k]);
         end
         rnd[k] = (za[k] + HALF) >>> SHIFT;
         if (rnd[k] > LIM) begin
            rnd[k] = LIM;
         end else if (rnd[k] < -LIM) begin
            rnd[k] = -LIM;
         end
         ang_in[k] = side_ff[CORDIC_STEPS].status ? '0 : rnd[k][ANG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         status_ff <= side_ff[CORDIC_STEPS].status;
         for (int k = 0; k < LANES; k++) begin
            ang_ff[k] <= ang_in[k];
         end
      end
   end

   `QYPR_ASSERT_IMPL(a_not_ready_zero, rsp_tvalid && rsp_tuser, rsp_tdata == '0, "not-ready result carries non-zero angles")
   `QYPR_ASSERT_IMPL(a_angle_range, rsp_tvalid, (ang_ff[0] <= LIM16) && (ang_ff[0] >= -LIM16) && (ang_ff[1] <= LIM16) && (ang_ff[1] >= -LIM16) && (ang_ff[2] <= LIM16) && (ang_ff[2] >= -LIM16), "angle beyond half a turn")
   `QYPR_ASSERT_IMPL(a_sqrt_rem, valid_ff[4+SQRT_STEPS-1], chain_sq[SQRT_STEPS].rem <= {2'b00, chain_sq[SQRT_STEPS].root, 1'b0}, "square root remainder too large")
   `QYPR_ASSERT_IMPL(a_prerot_x, valid_ff[4+SQRT_STEPS], (cr[0][0].x >= 0) && (cr[1][0].x >= 0) && (cr[2][0].x >= 0), "CORDIC start vector has negative x")

endmodule

FILE: tb/tb_quaternion_to_yaw_pitch_roll_core.sv
// Testbench of the quaternion to yaw, pitch and roll converter, checked against a bit-exact predictor.
module tb_quaternion_to_yaw_pitch_roll_core;
   localparam int FRAC = 7;
   localparam longint HALF_TURN = 64'sd11796480;
   localparam longint ATAN_DEG [20] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

   typedef struct packed {
      logic        status;
      logic [15:0] yaw;
      logic [15:0] pitch;
      logic [15:0] roll;
   } angles_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_wr_en = 0;
   logic        csr_wr_data = 0;

   logic [63:0] pending_quats [$];
   angles_type  expected_angles [$];
   logic        ready_copy = 0;
   logic        calm = 0;
   int          mismatches = 0;

   quaternion_to_yaw_pitch_roll_core #(.ANGLE_FRAC_BITS(FRAC)) dut (.*);

   initial forever #5 clock = ~clock;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint vector_angle(longint y, longint x);
      longint a;
      longint xs;
      longint ys;
      a = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         a = (y >= 0) ? HALF_TURN : -HALF_TURN;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < 20; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x += ys; y -= xs; a += ATAN_DEG[i];
         end else begin
            x -= ys; y += xs; a -= ATAN_DEG[i];
         end
      end
      return a;
   endfunction

   function automatic logic [15:0] round_angle(longint a);
      longint r;
      longint lim;
      lim = 64'sd180 <<< FRAC;
      r = (a + (64'sd1 <<< (15 - FRAC))) >>> (16 - FRAC);
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r[15:0];
   endfunction

   function automatic angles_type predict_angles(logic [63:0] q);
      longint w, x, y, z, gx, gy, gz, yy, yx, p;
      angles_type e;
      e = '0;
      if (!ready_copy) begin
         e.status = 1;
         return e;
      end
      w = longint'($signed(q[15:0]));
      x = longint'($signed(q[31:16]));
      y = longint'($signed(q[47:32]));
      z = longint'($signed(q[63:48]));
      gx = (2 * (x * z - w * y)) >>> 4;
      gy = (2 * (w * x + y * z)) >>> 4;
      gz = (w * w - x * x - y * y + z * z) >>> 4;
      yy = (2 * (x * y - w * z)) >>> 4;
      yx = (2 * (w * w + x * x) - (64'sd1 <<< 28)) >>> 4;
      p = vector_angle(gx, longint'(int_sqrt(gy * gy + gz * gz)));
      if (gz < 0) p = (p > 0) ? HALF_TURN - p : -HALF_TURN - p;
      e.yaw = round_angle(vector_angle(yy, yx));
      e.pitch = round_angle(p);
      e.roll = round_angle(vector_angle(gy, gz));
      return e;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) expected_angles.push_back(predict_angles(req_tdata));
         if (pending_quats.size() > 0 && (calm || $urandom_range(99) >= 28)) begin
            req_tdata <= pending_quats.pop_front();
            req_tvalid <= 1;
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   always @(posedge clock) begin
      angles_type got;
      angles_type want;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         rsp_tready <= calm || $urandom_range(99) >= 28;
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32]};
            if (expected_angles.size() == 0) begin
               $display("%0t unexpected transaction, expected none, actual %h", $time, got);
               mismatches++;
            end else begin
               want = expected_angles.pop_front();
               if (got.status !== want.status || got.yaw !== want.yaw ||
                   got.pitch !== want.pitch || got.roll !== want.roll) begin
                  $display("%0t mismatch: expected s=%0d y=%h p=%h r=%h, actual s=%0d y=%h p=%h r=%h",
                           $time, want.status, want.yaw, want.pitch, want.roll,
                           got.status, got.yaw, got.pitch, got.roll);
                  mismatches++;
               end
            end
         end
      end
   end

   function automatic logic [15:0] rand_word(bit unitish);
      if (unitish) return 16'($signed($urandom_range(32768)) - 16384);
      return 16'($urandom);
   endfunction

   task automatic queue_random(int n);
      bit u;
      for (int i = 0; i < n; i++) begin
         u = $urandom_range(99) < 50;
         pending_quats.push_back({rand_word(u), rand_word(u), rand_word(u), rand_word(u)});
      end
   endtask

   task automatic queue_directed();
      logic [15:0] v [5];
      v = '{16'h0000, 16'h7fff, 16'h8000, 16'h4000, 16'hc000};
      pending_quats.push_back(64'h0);
      pending_quats.push_back({48'h0, 16'h4000});
      for (int i = 1; i < 5; i++) begin
         pending_quats.push_back({4{v[i]}});
         pending_quats.push_back({v[i], 48'h0});
         pending_quats.push_back({16'h0, v[i], 32'h0});
         pending_quats.push_back({32'h0, v[i], 16'h0});
      end
      pending_quats.push_back({16'h0000, 16'h0000, 16'h4000, 16'h0000});
      pending_quats.push_back({16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
      pending_quats.push_back({16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
      pending_quats.push_back({16'h2d41, 16'h0000, 16'hd2bf, 16'h0000});
      pending_quats.push_back({16'h1000, 16'h3000, 16'hf000, 16'h0800});
   endtask

   task automatic drain_and_write(logic value);
      wait (pending_quats.size() == 0 && !req_tvalid && expected_angles.size() == 0);
      repeat (60) @(posedge clock);
      csr_wr_data <= value;
      csr_wr_en <= 1;
      @(posedge clock);
      csr_wr_en <= 0;
      ready_copy = value;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      queue_directed();
      queue_random(20);
      drain_and_write(1);
      queue_directed();
      queue_random(500);
      wait (pending_quats.size() < 300);
      calm = 1;
      wait (pending_quats.size() < 100);
      calm = 0;
      drain_and_write(0);
      queue_random(30);
      drain_and_write(1);
      queue_random(450);
      wait (pending_quats.size() == 0 && !req_tvalid && expected_angles.size() == 0);
      repeat (80) @(posedge clock);
      if (mismatches == 0 && expected_angles.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end
endmodule

FILE: files.f
+incdir+hdl
hdl/qypr_pkg.sv
hdl/qypr_sqrt_cell.sv
hdl/qypr_cordic_cell.sv
hdl/quaternion_to_yaw_pitch_roll_core.sv
tb/tb_quaternion_to_yaw_pitch_roll_core.sv
